FILE: src/alids_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the array list block.
// Holds opcode, status and controller state encodings; no dependencies.
package alids_pkg;

	// Default number of entries the list can hold.
	localparam int DEFAULT_CAPACITY = 32;

	localparam int DATA_W   = 32;
	localparam int FIELD6_W = 6;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_SEARCH = 3'd4,
		OP_DUMP   = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_BADPOS = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP,
		S_UP_END,
		S_UP_PUT,
		S_DN,
		S_DN_END,
		S_SCAN,
		S_SCAN_END,
		S_FLUSH
	} state_t;

endpackage

FILE: src/alids_mem.sv
`timescale 1ns / 1ps
// Entry store of the array list: one write port and one read port.
// Read data is registered. Uses alids_pkg.
module alids_mem import alids_pkg::*; #(
	parameter int DEPTH = DEFAULT_CAPACITY
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [DATA_W-1:0]                wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [DATA_W-1:0]                rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/alids_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the array list: decodes commands, walks the entry store
// through a registered read pipeline and registers each result word. Uses alids_pkg.
module alids_ctrl import alids_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   opcode,
	input  logic [FIELD6_W-1:0]          position,
	input  logic signed [DATA_W-1:0]     value,
	output logic                         mem_we,
	output logic [$clog2(CAPACITY)-1:0]  mem_waddr,
	output logic [DATA_W-1:0]            mem_wdata,
	output logic                         mem_re,
	output logic [$clog2(CAPACITY)-1:0]  mem_raddr,
	input  logic [DATA_W-1:0]            mem_rdata,
	output logic                         strobe,
	output logic [1:0]                   status,
	output logic                         found,
	output logic [FIELD6_W-1:0]          where,
	output logic signed [DATA_W-1:0]     data,
	output logic [FIELD6_W-1:0]          count,
	output logic                         last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = ((CW > FIELD6_W) ? CW : FIELD6_W) + 1;

	state_t state_q, state_d;

	logic [CW-1:0]     used_q, used_d;
	opcode_t           op_q, op_d;
	logic [DATA_W-1:0] key_q, key_d;
	logic [AW-1:0]     k_q, k_d;
	logic [AW-1:0]     ptr_q, ptr_d;

	logic              rd_vld_s1, rd_vld_d;
	logic              rd_end_s1, rd_end_d;
	logic [AW-1:0]     rd_addr_s1;

	logic              pend_v_q, pend_v_d;
	logic [FIELD6_W-1:0] pend_where_q, pend_where_d;
	logic [DATA_W-1:0] pend_data_q, pend_data_d;

	logic              res_v;
	status_t           res_status;
	logic              res_found;
	logic [FIELD6_W-1:0] res_where;
	logic [DATA_W-1:0] res_data;
	logic              res_last;

	logic              strobe_q;
	status_t           status_q;
	logic              found_q;
	logic [FIELD6_W-1:0] where_q;
	logic [DATA_W-1:0] data_q;
	logic [FIELD6_W-1:0] count_q;
	logic              last_q;

	logic              accept;
	logic              full;
	logic              empty;
	logic [AW-1:0]     last_idx;
	logic [PW-1:0]     pos_x;
	logic [PW-1:0]     used_x;
	logic              ins_ok;
	logic              ins_at_end;
	logic              del_ok;
	logic              del_at_end;
	logic [FIELD6_W-1:0] rd_where;
	logic              key_hit;

	assign accept     = start && (state_q == S_IDLE);
	assign full       = (used_q == CW'(CAPACITY));
	assign empty      = (used_q == '0);
	assign last_idx   = AW'(used_q - CW'(1));
	assign pos_x      = PW'(position);
	assign used_x     = PW'(used_q);
	assign ins_ok     = (pos_x != '0) && (pos_x <= used_x + PW'(1));
	assign ins_at_end = (pos_x == used_x + PW'(1));
	assign del_ok     = (pos_x != '0) && (pos_x <= used_x);
	assign del_at_end = (pos_x == used_x);
	assign rd_where   = FIELD6_W'(CW'(rd_addr_s1) + CW'(1));
	assign key_hit    = (mem_rdata == key_q);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_INSERT: begin
							if (!full && ins_ok && !ins_at_end) begin
								state_d = S_UP;
							end
						end
						OP_DELETE: begin
							if (!empty && del_ok && !del_at_end) begin
								state_d = S_DN;
							end
						end
						OP_SEARCH, OP_DUMP: begin
							if (!empty) begin
								state_d = S_SCAN;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_UP: begin
				if (ptr_q == k_q) begin
					state_d = S_UP_END;
				end
			end
			S_UP_END: state_d = S_UP_PUT;
			S_UP_PUT: state_d = S_IDLE;
			S_DN: begin
				if (ptr_q == last_idx) begin
					state_d = S_DN_END;
				end
			end
			S_DN_END: state_d = S_IDLE;
			S_SCAN: begin
				if (ptr_q == last_idx) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: state_d = (op_q == OP_SEARCH) ? S_FLUSH : S_IDLE;
			S_FLUSH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath, memory control and result generation.
	always_comb begin
		used_d       = used_q;
		op_d         = op_q;
		key_d        = key_q;
		k_d          = k_q;
		ptr_d        = ptr_q;
		rd_vld_d     = 1'b0;
		rd_end_d     = 1'b0;
		pend_v_d     = pend_v_q;
		pend_where_d = pend_where_q;
		pend_data_d  = pend_data_q;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = '0;
		mem_re       = 1'b0;
		mem_raddr    = ptr_q;
		res_v        = 1'b0;
		res_status   = STAT_OK;
		res_found    = 1'b0;
		res_where    = '0;
		res_data     = '0;
		res_last     = 1'b1;

		// Words coming back from the read pipeline.
		if (rd_vld_s1) begin
			case (op_q)
				OP_INSERT: begin
					mem_we    = 1'b1;
					mem_waddr = rd_addr_s1 + AW'(1);
					mem_wdata = mem_rdata;
				end
				OP_DELETE: begin
					mem_we    = 1'b1;
					mem_waddr = rd_addr_s1 - AW'(1);
					mem_wdata = mem_rdata;
				end
				OP_DUMP: begin
					res_v     = 1'b1;
					res_where = rd_where;
					res_data  = mem_rdata;
					res_last  = rd_end_s1;
				end
				OP_SEARCH: begin
					if (key_hit) begin
						// A new match releases the one held back, which is not last.
						if (pend_v_q) begin
							res_v     = 1'b1;
							res_found = 1'b1;
							res_where = pend_where_q;
							res_data  = pend_data_q;
							res_last  = 1'b0;
						end
						pend_v_d     = 1'b1;
						pend_where_d = rd_where;
						pend_data_d  = mem_rdata;
					end
				end
				default: ;
			endcase
		end

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_d     = opcode_t'(opcode);
					key_d    = value;
					k_d      = AW'(position - FIELD6_W'(1));
					pend_v_d = 1'b0;
					case (opcode)
						OP_CLEAR: begin
							used_d = '0;
							res_v  = 1'b1;
						end
						OP_APPEND: begin
							res_v = 1'b1;
							if (full) begin
								res_status = STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(used_q);
								mem_wdata = value;
								used_d    = used_q + CW'(1);
							end
						end
						OP_INSERT: begin
							if (full) begin
								res_v      = 1'b1;
								res_status = STAT_FULL;
							end else if (!ins_ok) begin
								res_v      = 1'b1;
								res_status = STAT_BADPOS;
							end else if (ins_at_end) begin
								res_v     = 1'b1;
								mem_we    = 1'b1;
								mem_waddr = AW'(used_q);
								mem_wdata = value;
								used_d    = used_q + CW'(1);
							end else begin
								ptr_d = last_idx;
							end
						end
						OP_DELETE: begin
							if (empty) begin
								res_v      = 1'b1;
								res_status = STAT_EMPTY;
							end else if (!del_ok) begin
								res_v      = 1'b1;
								res_status = STAT_BADPOS;
							end else if (del_at_end) begin
								res_v  = 1'b1;
								used_d = used_q - CW'(1);
							end else begin
								ptr_d = AW'(position);
							end
						end
						OP_SEARCH, OP_DUMP: begin
							if (empty) begin
								res_v      = 1'b1;
								res_status = STAT_EMPTY;
							end else begin
								ptr_d = '0;
							end
						end
						default: res_v = 1'b1;
					endcase
				end
			end
			S_UP: begin
				mem_re   = 1'b1;
				rd_vld_d = 1'b1;
				ptr_d    = ptr_q - AW'(1);
			end
			S_UP_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = k_q;
				mem_wdata = key_q;
				used_d    = used_q + CW'(1);
				res_v     = 1'b1;
			end
			S_DN: begin
				mem_re   = 1'b1;
				rd_vld_d = 1'b1;
				ptr_d    = ptr_q + AW'(1);
			end
			S_DN_END: begin
				used_d = used_q - CW'(1);
				res_v  = 1'b1;
			end
			S_SCAN: begin
				mem_re   = 1'b1;
				rd_vld_d = 1'b1;
				rd_end_d = (ptr_q == last_idx);
				ptr_d    = ptr_q + AW'(1);
			end
			S_FLUSH: begin
				res_v = 1'b1;
				if (pend_v_q) begin
					res_found = 1'b1;
					res_where = pend_where_q;
					res_data  = pend_data_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			rd_vld_s1 <= 1'b0;
			pend_v_q  <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			used_q    <= used_d;
			rd_vld_s1 <= rd_vld_d;
			pend_v_q  <= pend_v_d;
			strobe_q  <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		op_q         <= op_d;
		key_q        <= key_d;
		k_q          <= k_d;
		ptr_q        <= ptr_d;
		rd_end_s1    <= rd_end_d;
		rd_addr_s1   <= ptr_q;
		pend_where_q <= pend_where_d;
		pend_data_q  <= pend_data_d;
		if (res_v) begin
			status_q <= res_status;
			found_q  <= res_found;
			where_q  <= res_where;
			data_q   <= res_data;
			count_q  <= FIELD6_W'(used_d);
			last_q   <= res_last;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign status = status_q;
	assign found  = found_q;
	assign where  = where_q;
	assign data   = data_q;
	assign count  = count_q;
	assign last   = last_q;

endmodule

FILE: src/array_list_insert_delete_search.sv
`timescale 1ns / 1ps
// Top level of the fixed-capacity array list.
// Instantiates alids_ctrl and alids_mem; uses alids_pkg.

// An ordered list of up to CAPACITY signed 32-bit entries kept in a
// synchronous memory with one read and one write port. A command is taken
// when start is high and busy is low; its result words then appear one per
// cycle at most, each marked by strobe for exactly one cycle, and the final
// word of the command has last set. The receiver cannot hold words off, so
// it must take every strobed word. Clear, append, unused opcodes and any
// rejected command (full list, bad position, empty list) leave busy low
// and strobe their single word in the next cycle. Insert at position p of
// a list with n entries moves the tail up one entry per cycle, last entry
// first, then writes the value at p; delete at p moves each later entry
// down one place; dump and search read every entry in turn. This pace is
// set by the single memory read port: every entry that moves or is
// inspected costs one read, followed by the registered read data and a
// closing write or flush step. A search holds each match back one step so
// that the last match can carry the last flag. The memory content is not
// cleared at reset; only entries below the count are ever read.
module array_list_insert_delete_search import alids_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               opcode,
	input  logic [FIELD6_W-1:0]      position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     strobe,
	output logic [1:0]               status,
	output logic                     found,
	output logic [FIELD6_W-1:0]      where,
	output logic signed [DATA_W-1:0] data,
	output logic [FIELD6_W-1:0]      count,
	output logic                     last
);

	localparam int AW = $clog2(CAPACITY);

	// Memory port signals between the sequencer and the entry store.
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	alids_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.opcode   (opcode),
		.position (position),
		.value    (value),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.strobe   (strobe),
		.status   (status),
		.found    (found),
		.where    (where),
		.data     (data),
		.count    (count),
		.last     (last)
	);

	// The entry store; its read data is registered and returns in the cycle after the address.
	alids_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule
